[design/gfau_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the gf(2^8) arithmetic unit
// no dependencies
package gfau_pkg;

	localparam int unsigned GF_ORDER = 255;
	localparam int unsigned GF_SIZE  = 256;

	localparam logic [8:0] POLY_RESET = 9'd285;

	// operation codes
	localparam logic [1:0] OP_MUL    = 2'd0;
	localparam logic [1:0] OP_DIV    = 2'd1;
	localparam logic [1:0] OP_RECIP  = 2'd2;
	localparam logic [1:0] OP_REGION = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_FIELD_POLY    = 2'd0;
	localparam logic [1:0] REG_REGION_FACTOR = 2'd1;
	localparam logic [1:0] REG_ACCUMULATE    = 2'd2;

	// table write requests from the builder
	typedef struct packed {
		logic       busy;
		logic       log_we;
		logic [7:0] log_addr;
		logic [7:0] log_data;
		logic       alog_we;
		logic [7:0] alog_addr;
		logic [7:0] alog_data;
	} tbl_wr_t;

	// per-item control carried down the pipeline
	typedef struct packed {
		logic [1:0] op;
		logic       force_zero;
		logic       bypass;
		logic       xor_dest;
		logic       div_zero;
		logic [7:0] data_a;
		logic [7:0] dest;
		logic       last;
	} item_t;

endpackage

[design/gfau_builder.sv]
`timescale 1ns / 1ps
// log / antilog table build sequencer: clear pass, doubling walk, fixup
// depends on gfau_pkg
module gfau_builder (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [8:0]       poly,
	output gfau_pkg::tbl_wr_t wr
);
	import gfau_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_FILL  = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam logic [7:0] LAST_CLEAR = 8'(GF_SIZE - 1);
	localparam logic [7:0] LAST_FILL  = 8'(GF_ORDER - 1);

	logic [1:0] state_q;
	logic [7:0] cnt_q;
	logic [7:0] elem_q;
	logic [8:0] dbl;
	logic [7:0] elem_next;

	// doubling with reduction, masked back to eight bits
	always_comb begin
		dbl = {elem_q, 1'b0};
		if (dbl[8]) begin
			elem_next = 8'(dbl ^ poly);
		end else begin
			elem_next = dbl[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			elem_q  <= 8'd1;
		end else if (start) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
			elem_q  <= 8'd1;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 8'd1;
					if (cnt_q == LAST_CLEAR) begin
						state_q <= ST_FILL;
						elem_q  <= 8'd1;
					end
				end
				ST_FILL: begin
					cnt_q  <= cnt_q + 8'd1;
					elem_q <= elem_next;
					if (cnt_q == LAST_FILL) begin
						state_q <= ST_FINAL;
					end
				end
				ST_FINAL: state_q <= ST_DONE;
				ST_DONE:  state_q <= ST_DONE;
				default:  state_q <= ST_DONE;
			endcase
		end
	end

	always_comb begin
		wr = '0;
		wr.busy = (state_q != ST_DONE);
		unique case (state_q)
			ST_CLEAR: begin
				wr.log_we   = 1'b1;
				wr.log_addr = cnt_q;
				wr.log_data = '0;
			end
			ST_FILL: begin
				wr.log_we    = 1'b1;
				wr.log_addr  = elem_q;
				wr.log_data  = cnt_q;
				wr.alog_we   = 1'b1;
				wr.alog_addr = cnt_q;
				wr.alog_data = elem_q;
			end
			ST_FINAL: begin
				wr.log_we    = 1'b1;
				wr.log_addr  = '0;
				wr.log_data  = poly[7:0];
				wr.alog_we   = 1'b1;
				wr.alog_addr = 8'(GF_ORDER);
				wr.alog_data = 8'd1;
			end
			ST_DONE: ;
			default: ;
		endcase
	end

endmodule

[design/gf256_arithmetic_unit.sv]
`timescale 1ns / 1ps
// gf(2^8) arithmetic unit: multiply, divide, reciprocal and region bytes
// through log / antilog memories; depends on gfau_pkg and gfau_builder
//
// usage
//   input words arrive on s_tvalid/s_tready/s_tdata/s_tlast, one operation
//   each; results leave on m_tvalid/m_tready/m_tdata/m_tuser/m_tlast, one
//   word per input word, in order
//   configuration writes go over cfg_valid/cfg_ready/cfg_index/cfg_data and
//   are taken every cycle; index 0 sets the field polynomial, 1 the region
//   factor, 2 the accumulate flag, anything else is dropped
// timing
//   a result shows on m_tvalid after the log read on the accepting edge,
//   the antilog read and the output register; one word per cycle
//   sustained once the tables are built and while m_tready stays high
//   after reset and after every polynomial write the tables are rebuilt by
//   a pass of 256 log clears, 255 doubling steps and one fixup, during
//   which s_tready stays low
// stalls
//   every stage holds its word while the next stage is full and blocked, so
//   with m_tready low the pipe keeps filling until three words wait, then
//   s_tready drops; nothing is lost or repeated
module gf256_arithmetic_unit (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [1:0] op, [9:2] operand_a, [17:10] operand_b,
	                               // [25:18] dest_in, [31:26] zero
	input  logic        s_tlast,   // region_last
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] value
	output logic        m_tuser,   // [0] div_by_zero
	output logic        m_tlast,   // last
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);
	import gfau_pkg::*;

	// configuration registers
	logic [8:0] field_poly_q;
	logic [7:0] region_factor_q;
	logic       accumulate_q;
	logic       cfg_wr;
	logic       poly_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;
	assign poly_wr   = cfg_wr && (cfg_index == REG_FIELD_POLY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_poly_q    <= POLY_RESET;
			region_factor_q <= '0;
			accumulate_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_FIELD_POLY:    field_poly_q    <= cfg_data;
				REG_REGION_FACTOR: region_factor_q <= cfg_data[7:0];
				REG_ACCUMULATE:    accumulate_q    <= cfg_data[0];
				default:           ;
			endcase
		end
	end

	// table builder
	tbl_wr_t tw;

	gfau_builder u_builder (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (poly_wr),
		.poly   (field_poly_q),
		.wr     (tw)
	);

	// stage enables, each stage moves when the one below has room
	logic v1_q, v2_q, ov_q;
	logic out_en, en2, en1, accept;

	assign out_en   = !ov_q || m_tready;
	assign en2      = !v2_q || out_en;
	assign en1      = !v1_q || en2;
	assign s_tready = en1 && !tw.busy;
	assign accept   = s_tvalid && s_tready;

	// unpack the input word
	logic [1:0] in_op;
	logic [7:0] in_a, in_b, in_dest;

	assign in_op   = s_tdata[1:0];
	assign in_a    = s_tdata[9:2];
	assign in_b    = s_tdata[17:10];
	assign in_dest = s_tdata[25:18];

	// operand select and special cases, decided before the lookups
	logic       is_region;
	logic [7:0] mul_x, mul_y;
	item_t      item_in;

	always_comb begin
		is_region = (in_op == OP_REGION);
		mul_x     = is_region ? region_factor_q : in_a;
		mul_y     = is_region ? in_a : in_b;

		item_in          = '0;
		item_in.op       = in_op;
		item_in.data_a   = in_a;
		item_in.dest     = in_dest;
		item_in.last     = s_tlast;
		item_in.bypass   = is_region && (region_factor_q == 8'd1);
		item_in.xor_dest = is_region && accumulate_q;
		unique case (in_op)
			OP_MUL, OP_REGION: begin
				item_in.force_zero = (mul_x == '0) || (mul_y == '0);
			end
			OP_DIV: begin
				item_in.div_zero   = (in_b == '0);
				item_in.force_zero = (in_b == '0) || (in_a == '0);
			end
			OP_RECIP: begin
				item_in.div_zero   = (in_b == '0);
				item_in.force_zero = (in_b == '0);
			end
			default: ;
		endcase
	end

	// log memory: one write port for the builder, two read ports
	logic [7:0] log_mem [GF_SIZE];
	logic [7:0] la_s1, lb_s1;
	item_t      item_s1;

	always_ff @(posedge clk) begin
		if (tw.log_we) begin
			log_mem[tw.log_addr] <= tw.log_data;
		end
		if (en1) begin
			la_s1   <= log_mem[mul_x];
			lb_s1   <= log_mem[mul_y];
			item_s1 <= item_in;
		end
	end

	// exponent arithmetic modulo 255
	logic [8:0] exp_sum;
	logic [7:0] exp_addr;

	always_comb begin
		exp_sum = '0;
		unique case (item_s1.op)
			OP_MUL, OP_REGION: begin
				exp_sum = {1'b0, la_s1} + {1'b0, lb_s1};
				if (exp_sum >= 9'(GF_ORDER)) begin
					exp_sum = exp_sum - 9'(GF_ORDER);
				end
			end
			OP_DIV: begin
				if (la_s1 >= lb_s1) begin
					exp_sum = {1'b0, la_s1} - {1'b0, lb_s1};
				end else begin
					exp_sum = {1'b0, la_s1} + 9'(GF_ORDER) - {1'b0, lb_s1};
				end
			end
			OP_RECIP: exp_sum = 9'(GF_ORDER) - {1'b0, lb_s1};
			default:  exp_sum = '0;
		endcase
		exp_addr = exp_sum[7:0];
	end

	// antilog memory: one write port, one read port
	logic [7:0] alog_mem [GF_SIZE];
	logic [7:0] alog_s2;
	item_t      item_s2;

	always_ff @(posedge clk) begin
		if (tw.alog_we) begin
			alog_mem[tw.alog_addr] <= tw.alog_data;
		end
		if (en2) begin
			alog_s2 <= alog_mem[exp_addr];
			item_s2 <= item_s1;
		end
	end

	// final select, region accumulate
	logic [7:0] prod, val;

	always_comb begin
		priority if (item_s2.force_zero) begin
			prod = '0;
		end else if (item_s2.bypass) begin
			prod = item_s2.data_a;
		end else begin
			prod = alog_s2;
		end
		val = item_s2.xor_dest ? (prod ^ item_s2.dest) : prod;
	end

	// output register
	logic [7:0] value_q;
	logic       dz_q, last_q;

	always_ff @(posedge clk) begin
		if (out_en && v2_q) begin
			value_q <= val;
			dz_q    <= item_s2.div_zero;
			last_q  <= item_s2.last;
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			if (en1)    v1_q <= accept;
			if (en2)    v2_q <= v1_q;
			if (out_en) ov_q <= v2_q;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = value_q;
	assign m_tuser  = dz_q;
	assign m_tlast  = last_q;

	// checks
	a_dz_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("division by zero result not zero");

	a_poly_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		poly_wr |=> !s_tready)
		else $error("input taken while tables rebuild");

	a_ready_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !tw.busy && en1)
		else $error("ready raised during table build or full pipe");

	a_stall_keeps_result: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && !m_tready && v2_q |=> ov_q && v2_q)
		else $error("stalled result or waiting word dropped");

endmodule

[sim/gf256_arithmetic_unit_tb.sv]
`timescale 1ns / 1ps
// self-checking bench for gf256_arithmetic_unit: a directed table, then random phases
// over many field polynomials, factors and accumulate settings with random idling
// depends on gfau_pkg and gf256_arithmetic_unit
module gf256_arithmetic_unit_tb;
	import gfau_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int PHASES = 12;
	localparam int WORDS_PER_PHASE = 128;
	localparam int MAX_WAIT = 18;

	// one result word as the unit should send it
	typedef struct packed {
		logic [7:0] value;
		logic       div_zero;
		logic       last;
	} result_t;

	// one row of the directed table: an input word or a register write
	typedef struct packed {
		logic       is_reg;
		logic [1:0] code;     // op for words, register index for writes
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] dest;
		logic       last;
		logic       known;    // expected result typed in below
		logic [7:0] want;
		logic       want_dz;
		logic [8:0] reg_val;
	} step_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [1:0] op, [9:2] operand_a, [17:10] operand_b, [25:18] dest_in
	logic        s_tlast;   // region_last
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] value
	logic        m_tuser;   // [0] div_by_zero
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [8:0]  cfg_data;

	gf256_arithmetic_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// field model: log / power tables plus the register copies
	logic [7:0] log_of [0:255];
	logic [7:0] power_of [0:255];
	logic [7:0] factor_now;
	logic       accum_now;

	result_t results_due [$];
	step_t   directed [$];

	int errors;
	int words_sent;
	int words_checked;
	int regs_written;
	int polys_used;
	int dz_seen;
	int calm_src;
	int calm_sink;

	task automatic report_error(input string msg);
		$display("error at %0t ns: %s", $time, msg);
		errors++;
	endtask

	// idle cycles before the next word, with occasional stretches of none
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// walk the powers of 2 from 1, reducing whenever bit 8 comes up
	function automatic void build_field_tables(input logic [8:0] poly);
		logic [8:0] e;
		logic [8:0] j;
		for (int i = 0; i < GF_SIZE; i++) begin
			log_of[i] = 8'd0;
			power_of[i] = 8'd0;
		end
		e = 9'd1;
		for (j = 9'd0; j < GF_ORDER; j++) begin
			log_of[e[7:0]] = j[7:0];
			power_of[j[7:0]] = e[7:0];
			e = {e[7:0], 1'b0};
			if (e[8]) begin
				e = (e ^ poly) & 9'h0FF;
			end
		end
		power_of[255] = 8'd1;
		log_of[0] = poly[7:0];
	endfunction

	function automatic logic [7:0] field_product(input logic [7:0] x, input logic [7:0] y);
		logic [8:0] s;
		if (x == 8'd0 || y == 8'd0) begin
			return 8'd0;
		end
		s = {1'b0, log_of[x]} + {1'b0, log_of[y]};
		if (s >= GF_ORDER) begin
			s = s - 9'd255;
		end
		return power_of[s[7:0]];
	endfunction

	function automatic result_t predict_result(input logic [1:0] op, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] dest, input logic last);
		result_t r;
		logic [8:0] d;
		logic [7:0] prod;
		r = '0;
		r.last = last;
		case (op)
		OP_MUL: r.value = field_product(a, b);
		OP_DIV: begin
			if (b == 8'd0) begin
				r.div_zero = 1'b1;
			end else if (a != 8'd0) begin
				if (log_of[a] >= log_of[b]) begin
					d = {1'b0, log_of[a]} - {1'b0, log_of[b]};
				end else begin
					d = {1'b0, log_of[a]} + 9'd255 - {1'b0, log_of[b]};
				end
				r.value = power_of[d[7:0]];
			end
		end
		OP_RECIP: begin
			if (b == 8'd0) begin
				r.div_zero = 1'b1;
			end else begin
				r.value = power_of[8'd255 - log_of[b]];
			end
		end
		default: begin
			// factors 0 and 1 skip the tables
			if (factor_now == 8'd0) begin
				prod = 8'd0;
			end else if (factor_now == 8'd1) begin
				prod = a;
			end else begin
				prod = field_product(factor_now, a);
			end
			r.value = accum_now ? (dest ^ prod) : prod;
		end
		endcase
		return r;
	endfunction

	function automatic step_t word_row(input logic [1:0] op, input logic [7:0] a,
			input logic [7:0] b, input logic [7:0] dest, input logic last,
			input logic known, input logic [7:0] want, input logic want_dz);
		step_t s;
		s = '0;
		s.code = op;
		s.a = a;
		s.b = b;
		s.dest = dest;
		s.last = last;
		s.known = known;
		s.want = want;
		s.want_dz = want_dz;
		return s;
	endfunction

	function automatic step_t reg_row(input logic [1:0] idx, input logic [8:0] val);
		step_t s;
		s = '0;
		s.is_reg = 1'b1;
		s.code = idx;
		s.reg_val = val;
		return s;
	endfunction

	// cfg_valid stays up when another write follows at once
	task automatic write_reg(input logic [1:0] idx, input logic [8:0] data, input logic more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		if (!more) begin
			cfg_valid <= 1'b0;
		end
		regs_written++;
		case (idx)
		REG_FIELD_POLY: begin
			build_field_tables(data);
			polys_used++;
		end
		REG_REGION_FACTOR: factor_now = data[7:0];
		REG_ACCUMULATE: accum_now = data[0];
		default: ;
		endcase
	endtask

	// s_tvalid stays up when another word follows at once
	task automatic send_word(input logic [1:0] op, input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] dest, input logic last, input logic known,
			input logic [7:0] want, input logic want_dz, input logic more);
		int gap;
		result_t r;
		gap = draw_wait(calm_src);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, dest, b, a, op};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		if (!more) begin
			s_tvalid <= 1'b0;
		end
		r = predict_result(op, a, b, dest, last);
		if (known) begin
			r.value = want;
			r.div_zero = want_dz;
		end
		results_due.push_back(r);
		words_sent++;
	endtask

	task automatic drain();
		while (results_due.size() != 0) @(posedge clk);
	endtask

	// operands lean toward the zero, one and all-ones elements
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 9))
		0: return 8'h00;
		1: return 8'h01;
		2: return 8'hFF;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// result side: random stalls, every accepted word checked in order
	initial begin : sink
		int stall;
		result_t want;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_wait(calm_sink);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (results_due.size() == 0) begin
				report_error($sformatf("result word %02h with nothing outstanding", m_tdata));
			end else begin
				want = results_due.pop_front();
				words_checked++;
				if (want.div_zero) begin
					dz_seen++;
				end
				if (m_tdata !== want.value) begin
					report_error($sformatf("word %0d value %02h, want %02h",
						words_checked, m_tdata, want.value));
				end
				if (m_tuser !== want.div_zero) begin
					report_error($sformatf("word %0d div_by_zero %b, want %b",
						words_checked, m_tuser, want.div_zero));
				end
				if (m_tlast !== want.last) begin
					report_error($sformatf("word %0d last %b, want %b",
						words_checked, m_tlast, want.last));
				end
			end
		end
	end

	initial begin : timeout
		#5_000_000;
		$display("timeout: streams stalled with %0d results outstanding", results_due.size());
		$display("TEST FAILED");
		$finish;
	end

	initial begin : source
		step_t row;
		step_t nxt;
		logic more;
		logic [1:0] op;
		logic [8:0] poly;
		logic [7:0] factor;
		logic [7:0] junk;
		logic accum;

		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		errors = 0;
		words_sent = 0;
		words_checked = 0;
		regs_written = 0;
		polys_used = 1;
		dz_seen = 0;
		calm_src = 0;
		calm_sink = 0;
		factor_now = 8'd0;
		accum_now = 1'b0;
		build_field_tables(POLY_RESET);

		// reset settings: polynomial 0x11d, factor 0, overwrite
		directed.push_back(word_row(OP_MUL, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0));
		directed.push_back(word_row(OP_MUL, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0));
		directed.push_back(word_row(OP_MUL, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0));
		directed.push_back(word_row(OP_MUL, 8'h01, 8'h01, 8'h00, 1'b0, 1'b1, 8'h01, 1'b0));
		directed.push_back(word_row(OP_MUL, 8'h02, 8'h02, 8'h00, 1'b0, 1'b1, 8'h04, 1'b0));
		directed.push_back(word_row(OP_MUL, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0));
		directed.push_back(word_row(OP_MUL, 8'h53, 8'hCA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
		// zero divisor, zero dividend, x / x
		directed.push_back(word_row(OP_DIV, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1));
		directed.push_back(word_row(OP_DIV, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1));
		directed.push_back(word_row(OP_DIV, 8'h00, 8'h07, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0));
		directed.push_back(word_row(OP_DIV, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b1, 8'h01, 1'b0));
		directed.push_back(word_row(OP_DIV, 8'h80, 8'h02, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
		directed.push_back(word_row(OP_RECIP, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1, 8'h00, 1'b1));
		directed.push_back(word_row(OP_RECIP, 8'h00, 8'h01, 8'h00, 1'b0, 1'b1, 8'h01, 1'b0));
		directed.push_back(word_row(OP_RECIP, 8'h00, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
		directed.push_back(word_row(OP_RECIP, 8'h00, 8'h02, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
		// factor zero overwrites with zero
		directed.push_back(word_row(OP_REGION, 8'hFF, 8'h00, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0));
		// factor one passes the data byte straight into the xor
		directed.push_back(reg_row(REG_REGION_FACTOR, 9'h001));
		directed.push_back(reg_row(REG_ACCUMULATE, 9'h001));
		directed.push_back(word_row(OP_REGION, 8'hA5, 8'h00, 8'h0F, 1'b0, 1'b1, 8'hAA, 1'b0));
		directed.push_back(word_row(OP_REGION, 8'h00, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0));
		// upper data bits of narrow registers are dropped
		directed.push_back(reg_row(REG_REGION_FACTOR, 9'h1FF));
		directed.push_back(reg_row(REG_ACCUMULATE, 9'h1FE));
		directed.push_back(word_row(OP_REGION, 8'hFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0));
		directed.push_back(word_row(OP_REGION, 8'h01, 8'h00, 8'h55, 1'b0, 1'b1, 8'hFF, 1'b0));
		// index 3 must change nothing
		directed.push_back(reg_row(REG_UNUSED, 9'h1FF));
		directed.push_back(word_row(OP_REGION, 8'h02, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed table; a write group waits for every result first
		for (int i = 0; i < directed.size(); i++) begin
			row = directed[i];
			more = 1'b0;
			if (i + 1 < directed.size()) begin
				nxt = directed[i + 1];
				more = (nxt.is_reg == row.is_reg);
			end
			if (row.is_reg) begin
				drain();
				write_reg(row.code, row.reg_val, more);
			end else begin
				send_word(row.code, row.a, row.b, row.dest, row.last,
					row.known, row.want, row.want_dz, more);
			end
		end

		// random phases: extreme and odd polynomials first, then random ones
		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
			0: poly = 9'd511;
			1: poly = 9'd256;
			2: poly = 9'h11B;
			3: poly = 9'd0;
			4: poly = 9'd255;
			5: poly = POLY_RESET;
			default: poly = ($urandom_range(0, 3) == 0) ? 9'($urandom_range(0, 255))
				: 9'($urandom_range(256, 511));
			endcase
			case (p % 4)
			0: factor = 8'h00;
			1: factor = 8'h01;
			2: factor = 8'hFF;
			default: factor = 8'($urandom_range(2, 254));
			endcase
			accum = (p < 8) ? ((p / 4) % 2 == 1) : 1'($urandom_range(0, 1));
			junk = 8'($urandom_range(0, 255));
			write_reg(REG_FIELD_POLY, poly, 1'b1);
			write_reg(REG_REGION_FACTOR, {junk[7], factor}, 1'b1);
			write_reg(REG_ACCUMULATE, {junk, accum}, p % 3 == 2);
			if (p % 3 == 2) begin
				write_reg(REG_UNUSED, 9'($urandom_range(0, 511)), 1'b0);
			end
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				op = 2'($urandom_range(0, 3));
				send_word(op, pick_byte(), pick_byte(), 8'($urandom_range(0, 255)),
					(op == OP_REGION) ? ($urandom_range(0, 7) == 0)
						: 1'($urandom_range(0, 1)),
					1'b0, 8'h00, 1'b0, n != WORDS_PER_PHASE - 1);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (results_due.size() != 0) begin
			report_error($sformatf("%0d results never arrived", results_due.size()));
		end
		$display("ran %0d words, %0d checked, under %0d field polynomials",
			words_sent, words_checked, polys_used);
		$display("%0d register writes, %0d divide-by-zero results, %0d errors",
			regs_written, dz_seen, errors);
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
design/gfau_pkg.sv
design/gfau_builder.sv
design/gf256_arithmetic_unit.sv
sim/gf256_arithmetic_unit_tb.sv
